// ===== rtl/slcan_pkg.sv =====
package slcan_pkg;

   // Characters that the parser looks for.
   localparam logic [7:0] CHAR_UPPER_R = 8'h52;
   localparam logic [7:0] CHAR_UPPER_T = 8'h54;
   localparam logic [7:0] CHAR_LOWER_R = 8'h72;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] HEX_TEN      = 8'd10;

   // Position of the DLC digit for extended and standard lines.
   localparam logic [3:0] POS_DLC_EXT = 4'd9;
   localparam logic [3:0] POS_DLC_STD = 4'd4;

   // The character position saturates here; a character taken there marks the line as overlong.
   localparam logic [4:0] INDEX_TOP = 5'd31;

   typedef struct packed {
      logic        ok;
      logic        extended;
      logic        remote;
      logic [31:0] frame_id;
      logic [3:0]  byte_count;
      logic [63:0] payload;
   } slcan_result_type;

   // Hex digit conversion without any range check, modulo 256.
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CHAR_LOWER_A) begin
         v = c - CHAR_LOWER_A + HEX_TEN;
      end else if (c >= CHAR_UPPER_A) begin
         v = c - CHAR_UPPER_A + HEX_TEN;
      end else begin
         v = c - CHAR_ZERO;
      end
      return v;
   endfunction

endpackage

// ===== rtl/slcan_req_if.sv =====
interface slcan_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_line;

   modport source (output valid, output char_code, output end_of_line, input ready);
   modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

// ===== rtl/slcan_rsp_if.sv =====
interface slcan_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic        extended;
   logic        remote;
   logic [31:0] frame_id;
   logic [3:0]  byte_count;
   logic [63:0] payload;

   modport source (output valid, output ok, output extended, output remote, output frame_id,
                   output byte_count, output payload, input ready);
   modport sink   (input valid, input ok, input extended, input remote, input frame_id,
                   input byte_count, input payload, output ready);
endinterface

// ===== rtl/slcan_line_parser.sv =====
module slcan_line_parser
   import slcan_pkg::*;
#(
   parameter int MAX_DATA_BYTES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       char_code,
   input  logic             end_of_line,
   output slcan_result_type result
);

   logic [4:0]                          index_ff, index_in;
   logic                                is_ext_ff, is_ext_in;
   logic                                is_remote_ff, is_remote_in;
   logic [7:0]                          raw_dlc_ff, raw_dlc_in;
   logic [31:0]                         id_ff, id_in;
   logic [MAX_DATA_BYTES-1:0][7:0]      data_ff, data_in;
   logic [3:0]                          high_ff, high_in;
   logic                                overlong_ff, overlong_in;

   logic [7:0] nib;
   logic [7:0] pair;
   logic [3:0] dpos;
   logic [4:0] data_pos;
   logic [3:0] dpos_end;
   logic [4:0] dlc_end;
   logic       good;

   assign nib      = digit_value(char_code);
   assign pair     = {high_ff, 4'b0000} | nib;
   assign dpos     = is_ext_ff ? POS_DLC_EXT : POS_DLC_STD;
   assign data_pos = index_ff - 5'(dpos) - 5'd1;

   always_comb begin
      index_in     = index_ff;
      is_ext_in    = is_ext_ff;
      is_remote_in = is_remote_ff;
      raw_dlc_in   = raw_dlc_ff;
      id_in        = id_ff;
      data_in      = data_ff;
      high_in      = high_ff;
      overlong_in  = overlong_ff;

      if (index_ff == 5'd0) begin
         is_ext_in    = (char_code == CHAR_UPPER_R) || (char_code == CHAR_UPPER_T);
         is_remote_in = (char_code == CHAR_LOWER_R) || (char_code == CHAR_UPPER_R);
      end else if (index_ff < 5'(dpos)) begin
         if (is_ext_ff) begin
            if (index_ff[0]) begin
               high_in = nib[3:0];
            end else begin
               id_in = {id_ff[23:0], pair};
            end
         end else if (index_ff == 5'd1) begin
            id_in = 32'(nib);
         end else if (index_ff == 5'd2) begin
            high_in = nib[3:0];
         end else begin
            id_in = {16'h0000, id_ff[7:0], pair};
         end
      end else if (index_ff == 5'(dpos)) begin
         raw_dlc_in = char_code - CHAR_ZERO;
      end else if (!data_pos[0]) begin
         high_in = nib[3:0];
      end else begin
         // Second digit of a pair lands in its byte lane; lanes past the stored
         // ones can only belong to lines that fail the length check.
         for (int j = 0; j < MAX_DATA_BYTES; j++) begin
            if (data_pos[4:1] == 4'(j)) begin
               data_in[j] = data_ff[j] | pair;
            end
         end
      end

      if (index_ff == INDEX_TOP) begin
         overlong_in = 1'b1;
      end else begin
         index_in = index_ff + 5'd1;
      end
   end

   // Verdict on the line as it stands after this character.
   assign dpos_end = is_ext_in ? POS_DLC_EXT : POS_DLC_STD;
   assign dlc_end  = 5'(dpos_end) + 5'd1;

   always_comb begin
      good = !overlong_in && (index_in >= dlc_end)
             && (raw_dlc_in <= 8'(MAX_DATA_BYTES));
      if (is_remote_in) begin
         good = good && (index_in == dlc_end);
      end else begin
         good = good && ({1'b0, index_in} == ({1'b0, raw_dlc_in[3:0], 1'b0} + {1'b0, dlc_end}));
      end
   end

   always_comb begin
      result = '0;
      if (good) begin
         result.ok         = 1'b1;
         result.extended   = is_ext_in;
         result.remote     = is_remote_in;
         result.frame_id   = id_in;
         result.byte_count = raw_dlc_in[3:0];
         result.payload    = is_remote_in ? 64'h0 : 64'(data_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_line)) begin
         index_ff     <= '0;
         is_ext_ff    <= 1'b0;
         is_remote_ff <= 1'b0;
         raw_dlc_ff   <= '0;
         id_ff        <= '0;
         data_ff      <= '0;
         high_ff      <= '0;
         overlong_ff  <= 1'b0;
      end else if (step) begin
         index_ff     <= index_in;
         is_ext_ff    <= is_ext_in;
         is_remote_ff <= is_remote_in;
         raw_dlc_ff   <= raw_dlc_in;
         id_ff        <= id_in;
         data_ff      <= data_in;
         high_ff      <= high_in;
         overlong_ff  <= overlong_in;
      end
   end

endmodule

// ===== rtl/slcan_text_to_can_frame.sv =====
// Parses one serial-line CAN command, fed as ASCII characters one beat at a time with the
// last character flagged by end_of_line, into a single frame beat on the rsp channel. The
// line is a type letter ('T' extended data, 'R' extended remote, 'r' standard remote, any
// other letter standard data), 8 or 3 hex identifier digits, a DLC digit and, for data
// frames, two hex digits per data byte with byte zero landing in payload[7:0]. Hex digits
// are converted without validation. A line that is too short, longer than 31 characters,
// has a DLC above MAX_DATA_BYTES or whose length does not match its DLC comes out with ok
// low and every other field zero. The block takes one character per clock while no final
// character is held back: a beat is held in an input register, then folded into the line
// state, and on the last character the verdict is captured in an output register. Non-final
// characters never wait on the rsp side; a final character waits in the input register only
// while a previous frame beat is still held unaccepted. The frame beat is offered from the
// output register once the final character leaves the input register. Only one line is
// assembled at a time by construction, since the line state is the single accumulator.
module slcan_text_to_can_frame
   import slcan_pkg::*;
#(
   parameter int MAX_DATA_BYTES = 8
) (
   input logic       clock,
   input logic       reset,
   slcan_req_if.sink req_bus,
   slcan_rsp_if.source rsp_bus
);

   logic             in_valid_ff;
   logic [7:0]       in_char_ff;
   logic             in_eol_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   slcan_result_type rsp_data_ff;
   slcan_result_type line_result;
   logic             out_free;
   logic             step;
   logic             load_rsp;

   // The output register can take a new frame when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // A buffered character advances unless it ends a line and the output is blocked.
   assign step     = in_valid_ff && (!in_eol_ff || out_free);
   assign load_rsp = step && in_eol_ff;

   assign req_bus.ready = !in_valid_ff || step;

   slcan_line_parser #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .char_code   (in_char_ff),
      .end_of_line (in_eol_ff),
      .result      (line_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_char_ff <= req_bus.char_code;
         in_eol_ff  <= req_bus.end_of_line;
      end
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= line_result;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.ok         = rsp_data_ff.ok;
   assign rsp_bus.extended   = rsp_data_ff.extended;
   assign rsp_bus.remote     = rsp_data_ff.remote;
   assign rsp_bus.frame_id   = rsp_data_ff.frame_id;
   assign rsp_bus.byte_count = rsp_data_ff.byte_count;
   assign rsp_bus.payload    = rsp_data_ff.payload;

endmodule

// ===== rtl/slcan_chk.sv =====
module slcan_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        ok,
   input logic        extended,
   input logic        remote,
   input logic [31:0] frame_id,
   input logic [3:0]  byte_count,
   input logic [63:0] payload
);

   // A stalled frame beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(ok) && $stable(frame_id)
         && $stable(payload) && $stable(byte_count))
      else $error("frame beat changed while stalled");

   // A rejected line carries no frame content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !ok |-> !extended && !remote && (frame_id == 32'h0)
         && (byte_count == 4'd0) && (payload == 64'h0))
      else $error("rejected line with nonzero fields");

   // Remote frames never carry data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ok && remote |-> (payload == 64'h0))
      else $error("remote frame with payload");

   // Standard identifiers fit in sixteen bits, and an accepted DLC never exceeds eight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ok |-> (byte_count <= 4'd8) && (extended || (frame_id[31:16] == 16'h0)))
      else $error("accepted frame out of range");

endmodule

bind slcan_text_to_can_frame slcan_chk u_slcan_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .ok         (rsp_bus.ok),
   .extended   (rsp_bus.extended),
   .remote     (rsp_bus.remote),
   .frame_id   (rsp_bus.frame_id),
   .byte_count (rsp_bus.byte_count),
   .payload    (rsp_bus.payload)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import slcan_pkg::*;

   // The largest data length that a line may announce, handed to the block as well.
   localparam int FRAME_BYTES_MAX = 8;

   // Frame scoreboard. It keeps its own copy of the line state, folds in every character
   // beat that the block accepts, and queues one expected frame per final character.
   // Frame beats from the block are compared in order against that queue.
   class frame_scoreboard;
      logic [4:0]       pos;
      logic             ext;
      logic             rmt;
      logic             over;
      logic [7:0]       dlc_raw;
      logic [7:0]       hi;
      logic [31:0]      id;
      logic [63:0]      data;
      slcan_result_type expected_frames[$];
      int               mismatches;

      function new();
         mismatches = 0;
         clear_line();
      endfunction

      function void clear_line();
         pos     = '0;
         ext     = 1'b0;
         rmt     = 1'b0;
         over    = 1'b0;
         dlc_raw = '0;
         hi      = '0;
         id      = '0;
         data    = '0;
      endfunction

      // Hex digit value without any range check, wrapping modulo 256.
      function logic [7:0] nibble_of(logic [7:0] c);
         logic [7:0] v;
         if (c >= CHAR_LOWER_A) begin
            v = c - CHAR_LOWER_A + HEX_TEN;
         end else if (c >= CHAR_UPPER_A) begin
            v = c - CHAR_UPPER_A + HEX_TEN;
         end else begin
            v = c - CHAR_ZERO;
         end
         return v;
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction

      function string describe(slcan_result_type r);
         return $sformatf("ok=%0b ext=%0b rtr=%0b id=%h len=%0d data=%h",
                          r.ok, r.extended, r.remote, r.frame_id, r.byte_count, r.payload);
      endfunction

      function void note_char(logic [7:0] c, logic eol);
         logic [4:0]       p;
         logic [7:0]       nib;
         logic [7:0]       pair;
         logic [3:0]       dpos;
         int               k;
         int               len;
         bit               good;
         slcan_result_type r;
         p    = pos;
         nib  = nibble_of(c);
         pair = {hi[3:0], 4'h0} | nib;
         dpos = ext ? POS_DLC_EXT : POS_DLC_STD;
         if (p == 0) begin
            ext = (c == CHAR_UPPER_R) || (c == CHAR_UPPER_T);
            rmt = (c == CHAR_LOWER_R) || (c == CHAR_UPPER_R);
         end else if (p < dpos) begin
            if (ext) begin
               if (p[0]) begin
                  hi = nib;
               end else begin
                  id = {id[23:0], pair};
               end
            end else if (p == 1) begin
               id = {24'd0, nib};
            end else if (p == 2) begin
               hi = nib;
            end else begin
               id = {16'd0, id[7:0], pair};
            end
         end else if (p == dpos) begin
            dlc_raw = c - CHAR_ZERO;
         end else begin
            // Data digits pair up; anything past the eighth byte is dropped.
            k = int'(p) - int'(dpos) - 1;
            if (k % 2 == 0) begin
               hi = nib;
            end else if (k / 2 < 8) begin
               data = data | ({56'd0, pair} << (8 * (k / 2)));
            end
         end
         if (pos == INDEX_TOP) begin
            over = 1'b1;
         end else begin
            pos = pos + 5'd1;
         end
         if (!eol) begin
            return;
         end

         len = int'(pos);
         if (over) begin
            good = 1'b0;
         end else if (len < int'(dpos) + 1) begin
            good = 1'b0;
         end else if (int'(dlc_raw) > FRAME_BYTES_MAX) begin
            good = 1'b0;
         end else if (rmt) begin
            good = (len == int'(dpos) + 1);
         end else begin
            good = (len == 2 * int'(dlc_raw) + int'(dpos) + 1);
         end
         r = '0;
         if (good) begin
            r.ok         = 1'b1;
            r.extended   = ext;
            r.remote     = rmt;
            r.frame_id   = id;
            r.byte_count = dlc_raw[3:0];
            r.payload    = rmt ? 64'd0 : data;
         end
         expected_frames.push_back(r);
         clear_line();
      endfunction

      function void check_frame(slcan_result_type got);
         slcan_result_type want;
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected frame beat: %s", describe(got));
            end
            return;
         end
         want = expected_frames.pop_front();
         if (got.ok !== want.ok || got.extended !== want.extended ||
             got.remote !== want.remote || got.frame_id !== want.frame_id ||
             got.byte_count !== want.byte_count || got.payload !== want.payload) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("frame mismatch at %0t: expected %s", $realtime, describe(want));
               $display("                      actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   slcan_req_if req_bus ();
   slcan_rsp_if rsp_bus ();

   slcan_text_to_can_frame #(
      .MAX_DATA_BYTES(FRAME_BYTES_MAX)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   frame_scoreboard sb;

   // Idle rates in percent for the character sender and the frame receiver. The main
   // sequence changes them between phases of the run.
   int send_idle_pct;
   int recv_stall_pct;

   // Characters of the line being assembled, and a running count of sent characters.
   logic [7:0] line_text[$];
   int         chars_sent;

   always #1 clock = ~clock;

   // The run is bounded in time. A correct run finishes far earlier than this, even with
   // every final character held up by a stalled receiver.
   initial begin
      #1000000;
      $display("CHECK FAILED");
      $finish;
   end

   // The receiver drops ready at random; the draw happens at the falling edge so the
   // block sees a stable level at the next rising edge.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Both channels are watched at the rising edge. Everything sampled here was driven at
   // a falling edge, or comes from the block's registers before this edge updates them.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_char(req_bus.char_code, req_bus.end_of_line);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_frame('{ok: rsp_bus.ok, extended: rsp_bus.extended,
                             remote: rsp_bus.remote, frame_id: rsp_bus.frame_id,
                             byte_count: rsp_bus.byte_count, payload: rsp_bus.payload});
         end
      end
   end

   // Offers one character beat and returns at the falling edge after it was taken. The
   // valid line stays high across back-to-back beats, so it is never lowered and raised
   // again in the same time step.
   task automatic send_char(input logic [7:0] c, input logic eol);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.char_code   <= c;
      req_bus.end_of_line <= eol;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      chars_sent++;
      @(negedge clock);
   endtask

   // Sends the assembled line with the final character flagged, then empties it.
   task automatic send_line();
      int i;
      for (i = 0; i < line_text.size(); i++) begin
         send_char(line_text[i], i == line_text.size() - 1);
      end
      line_text.delete();
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         line_text.push_back(s[i]);
      end
   endtask

   task automatic add_byte(input logic [7:0] b);
      line_text.push_back(b);
   endtask

   // Appends one digit: mostly a proper hex digit in either case, now and then any byte,
   // since the block converts digits without checking them.
   task automatic add_hex_digit();
      logic [3:0] n;
      n = 4'($urandom_range(15));
      if ($urandom_range(9) == 0) begin
         add_byte(8'($urandom_range(255)));
      end else if (n < 10) begin
         add_byte(CHAR_ZERO + n);
      end else if ($urandom_range(1) == 1) begin
         add_byte(CHAR_UPPER_A + n - 8'd10);
      end else begin
         add_byte(CHAR_LOWER_A + n - 8'd10);
      end
   endtask

   // Hand-picked lines: every type letter, extreme identifiers and data, the largest and
   // smallest lengths, bad length codes, short and overlong lines, surplus data digits,
   // NUL and all-ones characters, and digits that are not hex at all.
   task automatic directed_lines();
      add_text("T000000000");
      send_line();
      add_text("TFFFFFFFF8FFFFFFFFFFFFFFFF");
      send_line();
      add_text("R1aBcDeF08");
      send_line();
      add_text("r7FF3");
      send_line();
      add_text("t12380123456789abcdef");
      send_line();
      add_text("xFFF0");
      send_line();
      add_text("tzzz0");
      send_line();
      // A length code of nine, one of ten, and one below the digit zero are all refused.
      add_text("t0009555555555555555555");
      send_line();
      add_text("t000:");
      send_line();
      add_text("t000/");
      send_line();
      // Lines that stop early or run on past their length code.
      add_text("T");
      send_line();
      add_text("t12");
      send_line();
      add_text("R12345678");
      send_line();
      add_text("t1232001");
      send_line();
      add_text("t12320011A");
      send_line();
      add_text("r1232AA");
      send_line();
      // A NUL is an ordinary character, here as the type letter and as a digit.
      add_byte(8'h00);
      add_text("1");
      add_byte(8'h00);
      add_text("20");
      send_line();
      add_text("tZZZ2gG!~");
      send_line();
      repeat (4) add_byte(8'hFF);
      add_text("1");
      repeat (2) add_byte(8'hFF);
      send_line();
      // Surplus data digits at 31 characters, then the overlong lengths 32 and 40.
      add_text("T123456788");
      repeat (21) add_text("a");
      send_line();
      add_text("T123456788");
      repeat (22) add_text("a");
      send_line();
      add_text("T123456788");
      repeat (30) add_text("7");
      send_line();
   endtask

   // Most random lines are well formed with random digits; some are damaged afterwards
   // (cut short, padded, a bad length code or a stray byte), and a few are pure noise.
   task automatic random_line();
      int         kind;
      int         n;
      int         dlc;
      int         dlc_pos;
      bit         is_ext;
      bit         is_rtr;
      logic [7:0] letter;
      kind = $urandom_range(99);
      if (kind >= 95) begin
         n = $urandom_range(1, 40);
         repeat (n) add_byte(8'($urandom_range(255)));
      end else begin
         case ($urandom_range(3))
            0: letter = CHAR_UPPER_T;
            1: letter = CHAR_UPPER_R;
            2: letter = CHAR_LOWER_R;
            default: begin
               letter = "t";
               if ($urandom_range(3) == 0) begin
                  do begin
                     letter = 8'($urandom_range(255));
                  end while (letter == CHAR_UPPER_T || letter == CHAR_UPPER_R ||
                             letter == CHAR_LOWER_R);
               end
            end
         endcase
         is_ext  = (letter == CHAR_UPPER_T) || (letter == CHAR_UPPER_R);
         is_rtr  = (letter == CHAR_LOWER_R) || (letter == CHAR_UPPER_R);
         dlc_pos = is_ext ? 9 : 4;
         add_byte(letter);
         repeat (is_ext ? 8 : 3) add_hex_digit();
         dlc = $urandom_range(FRAME_BYTES_MAX);
         add_byte(CHAR_ZERO + 8'(dlc));
         if (!is_rtr) begin
            repeat (2 * dlc) add_hex_digit();
         end
         if (kind >= 80) begin
            case ($urandom_range(3))
               0: begin
                  n = $urandom_range(1, line_text.size() - 1);
                  repeat (n) void'(line_text.pop_back());
               end
               1: begin
                  n = $urandom_range(1, 6);
                  repeat (n) add_hex_digit();
               end
               2: line_text[dlc_pos] = 8'($urandom_range(255));
               default: begin
                  line_text[$urandom_range(line_text.size() - 1)] = 8'($urandom_range(255));
               end
            endcase
         end
      end
      send_line();
   endtask

   initial begin
      int random_start;
      sb                  = new();
      chars_sent          = 0;
      send_idle_pct       = 13;
      recv_stall_pct      = 57;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.char_code   = '0;
      req_bus.end_of_line = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_lines();

      // Three random phases of about a third each: a slow receiver, then a slow sender,
      // then both at full rate.
      random_start = chars_sent;
      while (chars_sent - random_start < 720) begin
         if (chars_sent - random_start < 240) begin
            send_idle_pct  = 13;
            recv_stall_pct = 57;
         end else if (chars_sent - random_start < 480) begin
            send_idle_pct  = 57;
            recv_stall_pct = 13;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         random_line();
      end
      req_bus.valid <= 1'b0;

      // Drain: wait for every expected frame, then keep the clock running to catch any extra
      // beat the block might still put out.
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
